/* hdl/b85_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_pkg
// Shared types and constants for the base-85 encoder: item structs, job
// records passed between the front end, queue, converter and emitter.
// ----------------------------------------------------------------------------
package b85_pkg;

    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] LINE_LEN_RESET = 8'd78;
    localparam logic [7:0] MIN_LINE       = 8'd5;

    localparam logic [7:0] CHAR_BASE      = 8'd33;
    localparam logic [7:0] CHAR_MAX_DIGIT = 8'd117;
    localparam logic [7:0] CHAR_Z         = 8'd122;
    localparam logic [7:0] CHAR_NL        = 8'd10;

    // x / 85 == (x * RECIP_85) >> RECIP_SHIFT, exact for any 32-bit x
    localparam logic [31:0] RECIP_85    = 32'd3233857729;
    localparam int          RECIP_SHIFT = 38;

    localparam logic [2:0] LAST_DIGIT = 3'd4;
    localparam logic [1:0] LAST_STEP  = 2'd3;

    typedef struct packed {
        logic       opcode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        is_trailer;
        logic        last;
        logic [31:0] byte_count;
        logic [7:0]  xor_check;
        logic [31:0] sum_check;
        logic [31:0] rot_check;
    } out_item_t;

    typedef struct packed {
        logic [31:0] byte_count;
        logic [7:0]  xor_check;
        logic [31:0] sum_check;
        logic [31:0] rot_check;
    } checks_t;

    typedef struct packed {
        logic        has_word;
        logic [31:0] word;
        logic        has_trailer;
        checks_t     checks;
    } job_t;

    typedef struct packed {
        logic            has_word;
        logic            is_zero;
        logic [4:0][6:0] digits;
        logic            has_trailer;
        checks_t         checks;
    } enc_job_t;

endpackage

/* hdl/b85_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_front
// Accepts input items, keeps the running checks and the byte count, packs
// bytes into groups and posts one job per completed group or flush.
// ----------------------------------------------------------------------------
module b85_front import b85_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     push_valid,
    input  logic     push_ready,
    output job_t     push_job
);

    logic [31:0] group_word_reg, group_word_next;
    logic [1:0]  group_pos_reg, group_pos_next;
    logic [31:0] count_reg, count_next;
    logic [7:0]  xor_reg, xor_next;
    logic [31:0] sum_reg, sum_next;
    logic [31:0] rot_reg, rot_next;
    logic        accept;

    assign in_ready = push_ready;
    assign accept   = in_valid & push_ready;

    always_comb
    begin
        logic [31:0] word_full;
        logic [31:0] padded;

        group_word_next = group_word_reg;
        group_pos_next  = group_pos_reg;
        count_next      = count_reg;
        xor_next        = xor_reg;
        sum_next        = sum_reg;
        rot_next        = rot_reg;
        push_valid      = 1'b0;
        push_job        = '0;
        word_full       = {group_word_reg[23:0], in_data.data_byte};
        padded          = group_word_reg;

        if (in_data.opcode == OP_DATA)
        begin
            count_next = count_reg + 32'd1;
            xor_next   = xor_reg ^ in_data.data_byte;
            sum_next   = sum_reg + {24'b0, in_data.data_byte} + 32'd1;
            rot_next   = {rot_reg[30:0], rot_reg[31]} + {24'b0, in_data.data_byte};
            if (group_pos_reg == 2'd3)
            begin
                push_valid       = in_valid;
                push_job.has_word = 1'b1;
                push_job.word    = word_full;
                group_word_next  = '0;
                group_pos_next   = 2'd0;
            end
            else
            begin
                group_word_next = word_full;
                group_pos_next  = group_pos_reg + 2'd1;
            end
        end
        else
        begin
            // pad the open group with zero bytes
            case (group_pos_reg)
                2'd1:
                begin
                    padded   = {group_word_reg[7:0], 24'b0};
                    sum_next = sum_reg + 32'd3;
                    rot_next = {rot_reg[28:0], rot_reg[31:29]};
                end
                2'd2:
                begin
                    padded   = {group_word_reg[15:0], 16'b0};
                    sum_next = sum_reg + 32'd2;
                    rot_next = {rot_reg[29:0], rot_reg[31:30]};
                end
                2'd3:
                begin
                    padded   = {group_word_reg[23:0], 8'b0};
                    sum_next = sum_reg + 32'd1;
                    rot_next = {rot_reg[30:0], rot_reg[31]};
                end
                default:
                begin
                    padded = group_word_reg;
                end
            endcase
            push_valid                  = in_valid;
            push_job.has_word           = (group_pos_reg != 2'd0);
            push_job.word               = padded;
            push_job.has_trailer        = 1'b1;
            push_job.checks.byte_count  = count_reg;
            push_job.checks.xor_check   = xor_reg;
            push_job.checks.sum_check   = sum_next;
            push_job.checks.rot_check   = rot_next;
            group_word_next             = '0;
            group_pos_next              = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_word_reg <= '0;
            group_pos_reg  <= '0;
            count_reg      <= '0;
            xor_reg        <= '0;
            sum_reg        <= '0;
            rot_reg        <= '0;
        end
        else if (accept)
        begin
            group_word_reg <= group_word_next;
            group_pos_reg  <= group_pos_next;
            count_reg      <= count_next;
            xor_reg        <= xor_next;
            sum_reg        <= sum_next;
            rot_reg        <= rot_next;
        end
    end

endmodule

/* hdl/b85_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_fifo
// Short job queue between the front end and the converter.
// ----------------------------------------------------------------------------
module b85_fifo import b85_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + (QPTR_W+1)'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

/* hdl/b85_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_conv
// Base-85 digit converter: four divide-by-85 steps on one shared
// reciprocal multiplier, least significant digit first.
// ----------------------------------------------------------------------------
module b85_conv import b85_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     pop_valid,
    output logic     pop_ready,
    input  job_t     pop_job,
    output logic     enc_valid,
    input  logic     enc_ready,
    output enc_job_t enc_job
);

    logic            busy_reg;
    logic            done_reg;
    logic            phase_reg;
    logic [1:0]      step_reg;
    job_t            job_reg;
    logic            zero_reg;
    logic [31:0]     val_reg;
    logic [63:0]     prod_reg;
    logic [3:0][6:0] rem_reg;

    logic [63:0]     prod;
    logic [25:0]     quot;
    logic [13:0]     quot_x85;
    logic [7:0]      rem8;
    logic            handoff;
    logic            load;

    assign enc_valid = busy_reg & done_reg;
    assign handoff   = enc_valid & enc_ready;
    assign pop_ready = !busy_reg | handoff;
    assign load      = pop_valid & pop_ready;

    assign prod     = val_reg * RECIP_85;
    assign quot     = prod_reg[63:RECIP_SHIFT];
    // low byte of quot * 85 is enough: the remainder is below 85
    assign quot_x85 = {quot[7:0], 6'b0} + {2'b0, quot[7:0], 4'b0}
                    + {4'b0, quot[7:0], 2'b0} + {6'b0, quot[7:0]};
    assign rem8     = val_reg[7:0] - quot_x85[7:0];

    always_comb
    begin
        enc_job.has_word    = job_reg.has_word;
        enc_job.is_zero     = zero_reg;
        enc_job.digits[0]   = val_reg[6:0];
        enc_job.digits[1]   = rem_reg[3];
        enc_job.digits[2]   = rem_reg[2];
        enc_job.digits[3]   = rem_reg[1];
        enc_job.digits[4]   = rem_reg[0];
        enc_job.has_trailer = job_reg.has_trailer;
        enc_job.checks      = job_reg.checks;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            step_reg  <= '0;
        end
        else if (load)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= !(pop_job.has_word && (pop_job.word != '0));
            phase_reg <= 1'b0;
            step_reg  <= '0;
        end
        else if (handoff)
        begin
            busy_reg <= 1'b0;
        end
        else if (busy_reg && !done_reg)
        begin
            phase_reg <= !phase_reg;
            if (phase_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == LAST_STEP)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg  <= pop_job;
            zero_reg <= (pop_job.word == '0);
            val_reg  <= pop_job.word;
        end
        else if (busy_reg && !done_reg)
        begin
            if (!phase_reg)
            begin
                prod_reg <= prod;
            end
            else
            begin
                rem_reg[step_reg] <= rem8[6:0];
                val_reg           <= {6'b0, quot};
            end
        end
    end

endmodule

/* hdl/b85_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_emit
// Character emitter: sends digits or 'z', inserts newlines at the line
// length, appends the trailer and marks the last result of each item.
// ----------------------------------------------------------------------------
module b85_emit import b85_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic      enc_valid,
    output logic      enc_ready,
    input  enc_job_t  enc_job,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHAR  = 2'd1;
    localparam logic [1:0] ST_NL    = 2'd2;
    localparam logic [1:0] ST_TRAIL = 2'd3;

    logic [1:0] state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic [7:0] fill_reg, fill_next;
    logic [7:0] line_len_reg;
    enc_job_t   job_reg;
    logic       out_valid_reg;
    out_item_t  out_data_reg;

    logic       adv;
    logic       emit;
    logic       finish;
    logic       load;
    out_item_t  res;
    logic [7:0] lim;
    logic [7:0] fill_inc;
    logic       wrap;
    logic       at_end;

    assign adv       = !out_valid_reg | out_ready;
    assign lim       = (line_len_reg < MIN_LINE) ? MIN_LINE : line_len_reg;
    assign fill_inc  = fill_reg + 8'd1;
    assign wrap      = (fill_inc >= lim);
    assign at_end    = (idx_reg == (job_reg.is_zero ? 3'd0 : LAST_DIGIT));
    assign enc_ready = (state_reg == ST_IDLE) | finish;
    assign load      = enc_valid & enc_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        fill_next  = fill_reg;
        emit       = 1'b0;
        finish     = 1'b0;
        res        = '0;

        case (state_reg)
            ST_CHAR:
            begin
                if (adv)
                begin
                    emit         = 1'b1;
                    res.out_char = job_reg.is_zero ? CHAR_Z
                                 : {1'b0, job_reg.digits[idx_reg]} + CHAR_BASE;
                    res.last     = at_end & !wrap & !job_reg.has_trailer;
                    fill_next    = wrap ? 8'd0 : fill_inc;
                    if (wrap)
                    begin
                        state_next = ST_NL;
                    end
                    else if (at_end)
                    begin
                        if (job_reg.has_trailer)
                        begin
                            state_next = ST_TRAIL;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            ST_NL:
            begin
                if (adv)
                begin
                    emit         = 1'b1;
                    res.out_char = CHAR_NL;
                    res.last     = at_end & !job_reg.has_trailer;
                    if (at_end)
                    begin
                        if (job_reg.has_trailer)
                        begin
                            state_next = ST_TRAIL;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_CHAR;
                    end
                end
            end
            ST_TRAIL:
            begin
                if (adv)
                begin
                    emit           = 1'b1;
                    finish         = 1'b1;
                    res.is_trailer = 1'b1;
                    res.last       = 1'b1;
                    res.byte_count = job_reg.checks.byte_count;
                    res.xor_check  = job_reg.checks.xor_check;
                    res.sum_check  = job_reg.checks.sum_check;
                    res.rot_check  = job_reg.checks.rot_check;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
        begin
            state_next = enc_job.has_word ? ST_CHAR : ST_TRAIL;
            idx_next   = 3'd0;
        end
        else if (finish)
        begin
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            fill_reg      <= '0;
            line_len_reg  <= LINE_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            fill_reg  <= fill_next;
            if (cfg_wr_en)
            begin
                line_len_reg <= cfg_wr_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= enc_job;
        end
        if (emit)
        begin
            out_data_reg <= res;
        end
    end

endmodule

/* hdl/btoa_base85_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btoa_base85_encoder
// Byte stream to base-85 text with running checks and trailer report.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle until the four-entry job queue fills. Each
// completed group of four bytes holds the converter for a load step, then
// four divide-by-85 steps on one shared 32x32 reciprocal multiplier (an
// all-zero group skips the steps); the converter takes no new group until
// it has handed the last one to the emitter. The emitter sends one result
// per cycle while the receiver is ready: five digits or a 'z', newlines
// where the line fills, and the trailer of a flush. A flush pads the open
// group and then reports the count and checks in a trailer transfer marked
// last.
module btoa_base85_encoder import b85_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic     push_valid;
    logic     push_ready;
    job_t     push_job;
    logic     pop_valid;
    logic     pop_ready;
    job_t     pop_job;
    logic     enc_valid;
    logic     enc_ready;
    enc_job_t enc_job;

    b85_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    b85_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    b85_conv u_conv
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .enc_valid (enc_valid),
        .enc_ready (enc_ready),
        .enc_job   (enc_job)
    );

    b85_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .enc_valid   (enc_valid),
        .enc_ready   (enc_ready),
        .enc_job     (enc_job),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule

/* hdl/b85_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_checker
// Port-level checks on the encoder output stream, bound to the top level.
// ----------------------------------------------------------------------------
module b85_checker import b85_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transfer changed while stalled");

    a_trailer_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.is_trailer |-> out_data.last && out_data.out_char == 8'd0)
        else $error("trailer not marked last or carries a character");

    a_char_no_checks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_trailer |->
            out_data.byte_count == 32'd0 && out_data.xor_check == 8'd0 &&
            out_data.sum_check == 32'd0 && out_data.rot_check == 32'd0)
        else $error("character transfer carries check fields");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.is_trailer |->
            out_data.out_char == CHAR_NL || out_data.out_char == CHAR_Z ||
            (out_data.out_char >= CHAR_BASE && out_data.out_char <= CHAR_MAX_DIGIT))
        else $error("character outside the base-85 alphabet");

endmodule

bind btoa_base85_encoder b85_checker u_b85_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

/* test/b85_stream_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b85_stream_check
// Watches both channels of the base-85 encoder and the line length writes.
// Encodes each input transfer in step with the block, queues the characters
// and trailers it must send, and compares every output transfer field by
// field against the oldest queued result.
// ----------------------------------------------------------------------------
module b85_stream_check import b85_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_item_t   in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_item_t  out_data,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    output int         mismatches,
    output int         outstanding
);

    localparam logic [31:0] RADIX   = 32'd85;
    localparam logic [31:0] RADIX_2 = RADIX * RADIX;
    localparam logic [31:0] RADIX_3 = RADIX_2 * RADIX;
    localparam logic [31:0] RADIX_4 = RADIX_3 * RADIX;

    out_item_t   pending_results[$];
    out_item_t   held_result;
    logic        held_present;

    logic [31:0] group_word;
    logic [1:0]  group_pos;
    logic [7:0]  xor_sum;
    logic [31:0] plus_one_sum;
    logic [31:0] rotate_sum;
    logic [7:0]  line_fill;
    logic [31:0] real_bytes;
    logic [7:0]  line_length;

    // the last result of an item is held back so it can be marked last
    task automatic queue_result(input logic [7:0] ch, input logic trailer);
        out_item_t r;
        if (held_present)
            pending_results.push_back(held_result);
        r = '0;
        if (trailer)
        begin
            r.is_trailer = 1'b1;
            r.byte_count = real_bytes;
            r.xor_check  = xor_sum;
            r.sum_check  = plus_one_sum;
            r.rot_check  = rotate_sum;
        end
        else
        begin
            r.out_char = ch;
        end
        held_result  = r;
        held_present = 1'b1;
    endtask

    task automatic emit_digit(input logic [31:0] digit);
        logic [7:0] wrap_at;
        wrap_at = (line_length < MIN_LINE) ? MIN_LINE : line_length;
        queue_result(digit[7:0] + CHAR_BASE, 1'b0);
        line_fill = line_fill + 8'd1;
        if (line_fill >= wrap_at)
        begin
            queue_result(CHAR_NL, 1'b0);
            line_fill = 8'd0;
        end
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        logic [31:0] w;
        xor_sum      = xor_sum ^ b;
        plus_one_sum = plus_one_sum + {24'd0, b} + 32'd1;
        rotate_sum   = {rotate_sum[30:0], rotate_sum[31]} + {24'd0, b};
        group_word   = {group_word[23:0], b};
        if (group_pos == LAST_STEP)
        begin
            w = group_word;
            if (w == 32'd0)
            begin
                emit_digit({24'd0, CHAR_Z - CHAR_BASE});
            end
            else
            begin
                emit_digit(w / RADIX_4);
                w = w % RADIX_4;
                emit_digit(w / RADIX_3);
                w = w % RADIX_3;
                emit_digit(w / RADIX_2);
                w = w % RADIX_2;
                emit_digit(w / RADIX);
                emit_digit(w % RADIX);
            end
            group_word = 32'd0;
            group_pos  = 2'd0;
        end
        else
        begin
            group_pos = group_pos + 2'd1;
        end
    endtask

    task automatic encode_item(input in_item_t item);
        if (item.opcode == OP_DATA)
        begin
            real_bytes = real_bytes + 32'd1;
            absorb_byte(item.data_byte);
        end
        else
        begin
            while (group_pos != 2'd0)
                absorb_byte(8'h00);
            queue_result(8'h00, 1'b1);
        end
        if (held_present)
        begin
            held_result.last = 1'b1;
            pending_results.push_back(held_result);
            held_present = 1'b0;
        end
    endtask

    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("%0t ns: mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        mismatches = mismatches + 1;
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            report("unexpected transfer, char", 32'd0, {24'd0, got.out_char});
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.out_char !== want.out_char)
                report("out_char", {24'd0, want.out_char}, {24'd0, got.out_char});
            if (got.is_trailer !== want.is_trailer)
                report("is_trailer", {31'd0, want.is_trailer}, {31'd0, got.is_trailer});
            if (got.last !== want.last)
                report("last", {31'd0, want.last}, {31'd0, got.last});
            if (got.byte_count !== want.byte_count)
                report("byte_count", want.byte_count, got.byte_count);
            if (got.xor_check !== want.xor_check)
                report("xor_check", {24'd0, want.xor_check}, {24'd0, got.xor_check});
            if (got.sum_check !== want.sum_check)
                report("sum_check", want.sum_check, got.sum_check);
            if (got.rot_check !== want.rot_check)
                report("rot_check", want.rot_check, got.rot_check);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_results.delete();
            held_result  = '0;
            held_present = 1'b0;
            group_word   = 32'd0;
            group_pos    = 2'd0;
            xor_sum      = 8'd0;
            plus_one_sum = 32'd0;
            rotate_sum   = 32'd0;
            line_fill    = 8'd0;
            real_bytes   = 32'd0;
            line_length  = LINE_LEN_RESET;
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                line_length = cfg_wr_data;
            if (in_valid && in_ready)
                encode_item(in_data);
            if (out_valid && out_ready)
                compare_result(out_data);
            outstanding <= pending_results.size();
        end
    end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the base-85 encoder. Directed groups (zero, all
// ones, padded flushes) are followed by random byte streams under a range of
// line lengths, with random gaps on both channels, one long output stall and
// idle pauses for the line length writes. Checking is in b85_stream_check.
// ----------------------------------------------------------------------------
module tb import b85_pkg::*;
;

    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int HOLD_OFF_AFTER  = 24;
    localparam int SETTLE_CYCLES   = 40;
    localparam int PHASE_ITEMS     = 20;
    localparam int STRESS_ITEMS    = 40;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    in_item_t   in_data     = '0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    out_item_t  out_data;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;

    int mismatches;
    int outstanding;
    int accepted_in    = 0;
    int stalled_cycles = 0;

    always #5 clk = ~clk;

    btoa_base85_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    b85_stream_check stream_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic op, input logic [7:0] b);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{opcode: op, data_byte: b};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_word(input logic [31:0] w);
        send_item(OP_DATA, w[31:24]);
        send_item(OP_DATA, w[23:16]);
        send_item(OP_DATA, w[15:8]);
        send_item(OP_DATA, w[7:0]);
    endtask

    task automatic send_flush();
        send_item(OP_FLUSH, 8'($urandom));
    endtask

    // stop sending and wait for every queued result plus settle time
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_line_length(input logic [7:0] len);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_flush();
        else if (r < 16)
            send_word(32'd0);
        else if (r < 24)
            send_item(OP_DATA, 8'hFF);
        else if (r < 34)
            send_item(OP_DATA, 8'h00);
        else
            send_item(OP_DATA, 8'($urandom));
    endtask

    // transfer counter and stall watchdog
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            accepted_in <= accepted_in + 1;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // receiver: random ready bursts and gaps, one long hold-off
    initial
    begin
        int  ready_left;
        int  idle_left;
        bit  held_off;
        held_off   = 1'b0;
        ready_left = 0;
        idle_left  = 0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held_off && accepted_in >= HOLD_OFF_AFTER)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if (ready_left == 0 && idle_left == 0)
            begin
                ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 8);
                idle_left  = pick_gap();
            end
            if (ready_left > 0)
            begin
                out_ready  <= 1'b1;
                ready_left = ready_left - 1;
            end
            else
            begin
                out_ready <= 1'b0;
                idle_left = idle_left - 1;
            end
            @(posedge clk);
        end
    end

    initial
    begin
        logic [7:0] lengths [8];
        lengths = '{8'd1, 8'd4, 8'd5, 8'd6, 8'd255, 8'($urandom_range(7, 254)),
                    8'd2, LINE_LEN_RESET};
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset line length
        send_word(32'd0);
        send_word(32'hFFFF_FFFF);
        send_flush();
        send_item(OP_DATA, 8'h12);
        send_item(OP_DATA, 8'h34);
        send_flush();
        send_item(OP_DATA, 8'h00);
        send_flush();
        send_word(32'h8000_0000);

        // zero line length acts as the minimum
        write_line_length(8'd0);
        send_word(32'hFFFF_FFFF);
        send_flush();

        // long byte run while the receiver holds off, fills the queue
        for (int n = 0; n < STRESS_ITEMS; n++)
            send_item(OP_DATA, 8'($urandom));

        foreach (lengths[i])
        begin
            write_line_length(lengths[i]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_random_item();
        end
        send_flush();

        drain();
        if (mismatches == 0 && outstanding == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
